>>> design/sdp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sdp_pkg;

    localparam logic [2:0] OP_ARM    = 3'd0;
    localparam logic [2:0] OP_DISARM = 3'd1;
    localparam logic [2:0] OP_STEP   = 3'd2;
    localparam logic [2:0] OP_FAST   = 3'd3;
    localparam logic [2:0] OP_SLOW   = 3'd4;

    localparam logic [2:0] K_NOP  = 3'd0;
    localparam logic [2:0] K_ARM  = 3'd1;
    localparam logic [2:0] K_DIS  = 3'd2;
    localparam logic [2:0] K_STEP = 3'd3;
    localparam logic [2:0] K_FAST = 3'd4;
    localparam logic [2:0] K_SLOW = 3'd5;

    localparam logic [2:0] REG_CPP  = 3'd0;
    localparam logic [2:0] REG_DINV = 3'd1;
    localparam logic [2:0] REG_TPM  = 3'd2;
    localparam logic [2:0] REG_THR  = 3'd3;
    localparam logic [2:0] REG_SNUM = 3'd4;

    localparam logic [9:0]  CPP_RST  = 10'd5;
    localparam logic [15:0] TPM_RST  = 16'd1300;
    localparam logic [19:0] THR_RST  = 20'd5;
    localparam logic [31:0] SNUM_RST = 32'd787500000;
    localparam logic [15:0] MUL_K    = 16'd1000;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [2:0]         kind;
        logic [31:0]        ts;
        logic               pos;
        logic               en;
        logic signed [31:0] mpos;
        logic signed [31:0] mspd;
    } cmd_t;

    function automatic logic signed [31:0] clamp33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sh0_7FFF_FFFF)
            r = S32_MAX;
        else if (v < -33'sh0_8000_0000)
            r = S32_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [30:0] abs_sat(input logic signed [31:0] v);
        logic [31:0] n;
        n = -v;
        if (v == S32_MIN)
            return 31'h7FFF_FFFF;
        else if (v < 0)
            return n[30:0];
        else
            return v[30:0];
    endfunction

endpackage
`default_nettype wire

>>> design/sdp_front.sv
`timescale 1ns / 1ps
`default_nettype none
module sdp_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         op,
    input  wire logic [31:0]        timestamp,
    input  wire logic               direction,
    input  wire logic               enable_pin,
    input  wire logic signed [31:0] measured_position,
    input  wire logic signed [31:0] measured_speed,
    input  wire logic               dir_invert,
    output logic                    head_valid,
    output sdp_pkg::cmd_t           head,
    input  wire logic               pop
);
    sdp_pkg::cmd_t q_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          push;
    sdp_pkg::cmd_t cmd;

    always_comb
    begin
        unique case (op)
            sdp_pkg::OP_ARM:    cmd.kind = sdp_pkg::K_ARM;
            sdp_pkg::OP_DISARM: cmd.kind = sdp_pkg::K_DIS;
            sdp_pkg::OP_STEP:   cmd.kind = sdp_pkg::K_STEP;
            sdp_pkg::OP_FAST:   cmd.kind = sdp_pkg::K_FAST;
            sdp_pkg::OP_SLOW:   cmd.kind = sdp_pkg::K_SLOW;
            default:            cmd.kind = sdp_pkg::K_NOP;
        endcase
        cmd.ts   = timestamp;
        cmd.pos  = direction ^ dir_invert;
        cmd.en   = enable_pin;
        cmd.mpos = measured_position;
        cmd.mspd = measured_speed;
    end

    assign in_stall   = (cnt_reg == 2'd2);
    assign push       = in_valid && !in_stall;
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= cmd;
    end
endmodule
`default_nettype wire

>>> design/sdp_div.sv
`timescale 1ns / 1ps
`default_nettype none
module sdp_div #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [31:0]          num,
    input  wire logic [TIME_BITS-1:0] den,
    output logic                      busy,
    output logic                      done,
    output logic [31:0]               quo
);
    logic [TIME_BITS-1:0] rem_reg, rem_next;
    logic [31:0]          quo_reg, quo_next;
    logic [TIME_BITS-1:0] den_reg, den_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [TIME_BITS:0]   trial;
    logic [TIME_BITS:0]   diff;

    // one quotient bit per cycle, restoring
    assign trial = {rem_reg, quo_reg[31]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = diff[TIME_BITS-1:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial[TIME_BITS-1:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;
endmodule
`default_nettype wire

>>> design/sdp_back.sv
`timescale 1ns / 1ps
`default_nettype none
module sdp_back #(
    parameter int TIME_BITS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               head_valid,
    input  wire sdp_pkg::cmd_t      head,
    output logic                    pop,
    input  wire logic [9:0]         cpp,
    input  wire logic [15:0]        tpm,
    input  wire logic [19:0]        thr,
    input  wire logic [31:0]        snum,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      reference_position,
    output logic signed [31:0]      reference_speed,
    output logic                    stream_running,
    output logic                    armed,
    output logic [31:0]             accepted_pulses,
    output logic [31:0]             ignored_pulses,
    output logic [30:0]             peak_position_error,
    output logic [30:0]             peak_speed_error,
    output logic                    tracking_started,
    output logic signed [31:0]      first_error_position,
    output logic signed [31:0]      last_step_error,
    output logic [31:0]             motion_samples
);
    localparam int PW = TIME_BITS + 16;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_ERR  = 3'd5;
    localparam logic [2:0] S_UPD  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0]           state_reg, state_next;
    sdp_pkg::cmd_t        cmd_reg, cmd_next;
    logic signed [31:0]   ref_reg, ref_next;
    logic [31:0]          pend_reg, pend_next;
    logic [TIME_BITS-1:0] last_t_reg, last_t_next;
    logic [TIME_BITS-1:0] intv_reg, intv_next;
    logic                 neg_reg, neg_next;
    logic                 ivalid_reg, ivalid_next;
    logic                 armed_reg, armed_next;
    logic                 active_reg, active_next;
    logic signed [31:0]   speed_reg, speed_next;
    logic [31:0]          acc_reg, acc_next;
    logic [31:0]          ign_reg, ign_next;
    logic [30:0]          maxp_reg, maxp_next;
    logic [30:0]          maxs_reg, maxs_next;
    logic                 started_reg, started_next;
    logic signed [31:0]   first_reg, first_next;
    logic signed [31:0]   stepe_reg, stepe_next;
    logic [31:0]          motion_reg, motion_next;
    logic                 dnz_reg, dnz_next;
    logic signed [31:0]   perr_reg, perr_next;
    logic signed [31:0]   serr_reg, serr_next;
    logic [PW-1:0]        me_reg, me_next;
    logic [PW-1:0]        mi_reg, mi_next;
    logic [PW-1:0]        pe_reg, pe_next;
    logic [PW-1:0]        pi_reg, pi_next;
    logic [3:0]           mcnt_reg, mcnt_next;
    logic                 ov_reg, ov_next;

    logic [TIME_BITS+31:0] ts_ext;
    logic [TIME_BITS-1:0]  ts_w;
    logic [TIME_BITS-1:0]  since;
    logic signed [32:0]    step_sum;
    logic                  div_start, div_busy, div_done;
    logic [31:0]           div_quo;
    logic signed [31:0]    spd_sat;
    logic [31:0]           neg_quo;
    logic [30:0]           ap, as_v;
    logic                  fin_load;

    assign ts_ext   = {{TIME_BITS{1'b0}}, cmd_reg.ts};
    assign ts_w     = ts_ext[TIME_BITS-1:0];
    assign since    = ts_w - last_t_reg;
    assign step_sum = cmd_reg.pos ? {ref_reg[31], ref_reg} + {23'd0, cpp}
                                  : {ref_reg[31], ref_reg} - {23'd0, cpp};
    assign neg_quo  = -div_quo;
    assign ap       = sdp_pkg::abs_sat(perr_reg);
    assign as_v     = sdp_pkg::abs_sat(serr_reg);
    assign fin_load = (state_reg == S_FIN) && (!ov_reg || !out_stall);

    // sign the quotient by the last step, then saturate
    always_comb
    begin
        if (neg_reg)
            spd_sat = (div_quo > 32'h8000_0000) ? sdp_pkg::S32_MIN : $signed(neg_quo);
        else
            spd_sat = div_quo[31] ? sdp_pkg::S32_MAX : $signed(div_quo);
    end

    sdp_div #(.TIME_BITS(TIME_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (snum),
        .den   (intv_reg),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        ref_next     = ref_reg;
        pend_next    = pend_reg;
        last_t_next  = last_t_reg;
        intv_next    = intv_reg;
        neg_next     = neg_reg;
        ivalid_next  = ivalid_reg;
        armed_next   = armed_reg;
        active_next  = active_reg;
        speed_next   = speed_reg;
        acc_next     = acc_reg;
        ign_next     = ign_reg;
        maxp_next    = maxp_reg;
        maxs_next    = maxs_reg;
        started_next = started_reg;
        first_next   = first_reg;
        stepe_next   = stepe_reg;
        motion_next  = motion_reg;
        dnz_next     = dnz_reg;
        perr_next    = perr_reg;
        serr_next    = serr_reg;
        me_next      = me_reg;
        mi_next      = mi_reg;
        pe_next      = pe_reg;
        pi_next      = pi_reg;
        mcnt_next    = mcnt_reg;
        pop          = 1'b0;
        div_start    = 1'b0;
        ov_next      = out_stall ? ov_reg : 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    cmd_next   = head;
                    pop        = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_FIN;
                case (cmd_reg.kind)
                    sdp_pkg::K_ARM:
                    begin
                        ref_next     = cmd_reg.mpos;
                        pend_next    = '0;
                        last_t_next  = ts_w;
                        intv_next    = '0;
                        neg_next     = 1'b0;
                        ivalid_next  = 1'b0;
                        active_next  = 1'b0;
                        speed_next   = '0;
                        acc_next     = '0;
                        ign_next     = '0;
                        maxp_next    = '0;
                        maxs_next    = '0;
                        started_next = 1'b0;
                        first_next   = '0;
                        stepe_next   = '0;
                        motion_next  = '0;
                        armed_next   = 1'b1;
                    end
                    sdp_pkg::K_DIS:
                    begin
                        armed_next = 1'b0;
                        speed_next = '0;
                    end
                    sdp_pkg::K_STEP:
                    begin
                        if (!armed_reg || !cmd_reg.en)
                            ign_next = ign_reg + 32'd1;
                        else
                        begin
                            ref_next = sdp_pkg::clamp33(step_sum);
                            if (ivalid_reg)
                                intv_next = since;
                            last_t_next = ts_w;
                            neg_next    = !cmd_reg.pos;
                            ivalid_next = 1'b1;
                            pend_next   = cmd_reg.pos ? pend_reg + 32'd1 : pend_reg - 32'd1;
                            acc_next    = acc_reg + 32'd1;
                        end
                    end
                    sdp_pkg::K_FAST:
                    begin
                        if (armed_reg)
                        begin
                            if (cmd_reg.en && ivalid_reg && intv_reg != '0)
                            begin
                                me_next    = {16'd0, since};
                                mi_next    = {16'd0, intv_reg};
                                pe_next    = '0;
                                pi_next    = '0;
                                mcnt_next  = '0;
                                state_next = S_MUL;
                            end
                            else
                                active_next = 1'b0;
                        end
                    end
                    sdp_pkg::K_SLOW:
                    begin
                        if (armed_reg)
                        begin
                            dnz_next  = cmd_reg.en && (pend_reg != '0);
                            pend_next = '0;
                            if (ivalid_reg && intv_reg != '0 && active_reg)
                            begin
                                div_start  = 1'b1;
                                state_next = S_DIV;
                            end
                            else
                            begin
                                speed_next = '0;
                                state_next = S_ERR;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_MUL:
            begin
                // shift-add both products, one multiplier bit per cycle
                if (tpm[mcnt_reg])
                    pi_next = pi_reg + mi_reg;
                if (sdp_pkg::MUL_K[mcnt_reg])
                    pe_next = pe_reg + me_reg;
                mi_next   = {mi_reg[PW-2:0], 1'b0};
                me_next   = {me_reg[PW-2:0], 1'b0};
                mcnt_next = mcnt_reg + 4'd1;
                if (mcnt_reg == 4'd15)
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                active_next = (pe_reg <= pi_reg);
                state_next  = S_FIN;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    speed_next = spd_sat;
                    state_next = S_ERR;
                end
            end
            S_ERR:
            begin
                perr_next  = sdp_pkg::clamp33({ref_reg[31], ref_reg}
                                              - {cmd_reg.mpos[31], cmd_reg.mpos});
                serr_next  = sdp_pkg::clamp33({speed_reg[31], speed_reg}
                                              - {cmd_reg.mspd[31], cmd_reg.mspd});
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (dnz_reg || speed_reg != '0)
                begin
                    if (ap > maxp_reg)
                        maxp_next = ap;
                    if (!started_reg && {1'b0, ap} >= {12'd0, thr})
                    begin
                        started_next = 1'b1;
                        first_next   = perr_reg;
                    end
                    if (as_v > maxs_reg)
                        maxs_next = as_v;
                    motion_next = motion_reg + 32'd1;
                end
                if (dnz_reg)
                    stepe_next = perr_reg;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (fin_load)
                begin
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ov_reg      <= 1'b0;
            ref_reg     <= '0;
            pend_reg    <= '0;
            last_t_reg  <= '0;
            intv_reg    <= '0;
            neg_reg     <= 1'b0;
            ivalid_reg  <= 1'b0;
            armed_reg   <= 1'b0;
            active_reg  <= 1'b0;
            speed_reg   <= '0;
            acc_reg     <= '0;
            ign_reg     <= '0;
            maxp_reg    <= '0;
            maxs_reg    <= '0;
            started_reg <= 1'b0;
            first_reg   <= '0;
            stepe_reg   <= '0;
            motion_reg  <= '0;
            mcnt_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            ov_reg      <= ov_next;
            ref_reg     <= ref_next;
            pend_reg    <= pend_next;
            last_t_reg  <= last_t_next;
            intv_reg    <= intv_next;
            neg_reg     <= neg_next;
            ivalid_reg  <= ivalid_next;
            armed_reg   <= armed_next;
            active_reg  <= active_next;
            speed_reg   <= speed_next;
            acc_reg     <= acc_next;
            ign_reg     <= ign_next;
            maxp_reg    <= maxp_next;
            maxs_reg    <= maxs_next;
            started_reg <= started_next;
            first_reg   <= first_next;
            stepe_reg   <= stepe_next;
            motion_reg  <= motion_next;
            mcnt_reg    <= mcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        dnz_reg  <= dnz_next;
        perr_reg <= perr_next;
        serr_reg <= serr_next;
        me_reg   <= me_next;
        mi_reg   <= mi_next;
        pe_reg   <= pe_next;
        pi_reg   <= pi_next;
        if (fin_load)
        begin
            reference_position   <= ref_reg;
            reference_speed      <= speed_reg;
            stream_running       <= active_reg;
            armed                <= armed_reg;
            accepted_pulses      <= acc_reg;
            ignored_pulses       <= ign_reg;
            peak_position_error  <= maxp_reg;
            peak_speed_error     <= maxs_reg;
            tracking_started     <= started_reg;
            first_error_position <= first_reg;
            last_step_error      <= stepe_reg;
            motion_samples       <= motion_reg;
        end
    end

    assign out_valid = ov_reg;

`ifndef ASSERT_OFF
    a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == S_DIV))
        else $error("divider busy outside divide state");
    a_pop_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == S_IDLE) && head_valid)
        else $error("queue popped outside idle");
    a_arm_sets_armed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && cmd_reg.kind == sdp_pkg::K_ARM) |=> armed_reg && !ivalid_reg)
        else $error("arm did not set armed state");
`endif
endmodule
`default_nettype wire

>>> design/step_dir_pulse_reference.sv
`timescale 1ns / 1ps
`default_nettype none
// Step/direction reference for a servo loop. Items enter a two-entry command queue
// and are executed one at a time. Arm, disarm, step edges, unknown ops and ticks
// while disarmed go from the execute state straight to the output state; a fast
// tick compares elapsed*1000 against interval*permille with a shift-add multiplier
// and a compare state; a slow tick runs a restoring divide for the speed while
// the stream is running, then the error update. One result item per input item,
// in order, held in an output register so the next item runs while a result waits.
module step_dir_pulse_reference #(
    parameter int TIME_BITS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         op,
    input  wire logic [31:0]        timestamp,
    input  wire logic               direction,
    input  wire logic               enable_pin,
    input  wire logic signed [31:0] measured_position,
    input  wire logic signed [31:0] measured_speed,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      reference_position,
    output logic signed [31:0]      reference_speed,
    output logic                    stream_running,
    output logic                    armed,
    output logic [31:0]             accepted_pulses,
    output logic [31:0]             ignored_pulses,
    output logic [30:0]             peak_position_error,
    output logic [30:0]             peak_speed_error,
    output logic                    tracking_started,
    output logic signed [31:0]      first_error_position,
    output logic signed [31:0]      last_step_error,
    output logic [31:0]             motion_samples
);
    logic [9:0]    cpp_reg;
    logic          dinv_reg;
    logic [15:0]   tpm_reg;
    logic [19:0]   thr_reg;
    logic [31:0]   snum_reg;
    logic          wr_en;
    logic [2:0]    ridx;
    logic          head_valid;
    sdp_pkg::cmd_t head;
    logic          pop;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign ridx   = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpp_reg  <= sdp_pkg::CPP_RST;
            dinv_reg <= 1'b0;
            tpm_reg  <= sdp_pkg::TPM_RST;
            thr_reg  <= sdp_pkg::THR_RST;
            snum_reg <= sdp_pkg::SNUM_RST;
        end
        else if (wr_en)
        begin
            unique case (ridx)
                sdp_pkg::REG_CPP:  cpp_reg  <= pwdata[9:0];
                sdp_pkg::REG_DINV: dinv_reg <= pwdata[0];
                sdp_pkg::REG_TPM:  tpm_reg  <= pwdata[15:0];
                sdp_pkg::REG_THR:  thr_reg  <= pwdata[19:0];
                sdp_pkg::REG_SNUM: snum_reg <= pwdata;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (ridx)
            sdp_pkg::REG_CPP:  prdata = {22'd0, cpp_reg};
            sdp_pkg::REG_DINV: prdata = {31'd0, dinv_reg};
            sdp_pkg::REG_TPM:  prdata = {16'd0, tpm_reg};
            sdp_pkg::REG_THR:  prdata = {12'd0, thr_reg};
            sdp_pkg::REG_SNUM: prdata = snum_reg;
            default:           prdata = '0;
        endcase
    end

    sdp_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .op                (op),
        .timestamp         (timestamp),
        .direction         (direction),
        .enable_pin        (enable_pin),
        .measured_position (measured_position),
        .measured_speed    (measured_speed),
        .dir_invert        (dinv_reg),
        .head_valid        (head_valid),
        .head              (head),
        .pop               (pop)
    );

    sdp_back #(.TIME_BITS(TIME_BITS)) u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .head_valid           (head_valid),
        .head                 (head),
        .pop                  (pop),
        .cpp                  (cpp_reg),
        .tpm                  (tpm_reg),
        .thr                  (thr_reg),
        .snum                 (snum_reg),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .reference_position   (reference_position),
        .reference_speed      (reference_speed),
        .stream_running       (stream_running),
        .armed                (armed),
        .accepted_pulses      (accepted_pulses),
        .ignored_pulses       (ignored_pulses),
        .peak_position_error  (peak_position_error),
        .peak_speed_error     (peak_speed_error),
        .tracking_started     (tracking_started),
        .first_error_position (first_error_position),
        .last_step_error      (last_step_error),
        .motion_samples       (motion_samples)
    );
endmodule
`default_nettype wire

>>> sim/step_dir_pulse_reference_test.sv
`timescale 1ns / 1ps
module step_dir_pulse_reference_test;

    typedef struct packed {
        logic [2:0]         op;
        logic [31:0]        ts;
        logic               dir;
        logic               en;
        logic signed [31:0] mpos;
        logic signed [31:0] mspd;
    } event_t;

    typedef struct packed {
        logic signed [31:0] rpos;
        logic signed [31:0] rspd;
        logic               active;
        logic               armed;
        logic [31:0]        acc;
        logic [31:0]        ign;
        logic [30:0]        pk_pos;
        logic [30:0]        pk_spd;
        logic               started;
        logic signed [31:0] first;
        logic signed [31:0] last;
        logic [31:0]        motion;
    } status_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    event_t drv = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    status_t got;

    step_dir_pulse_reference dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(drv.op), .timestamp(drv.ts), .direction(drv.dir), .enable_pin(drv.en),
        .measured_position(drv.mpos), .measured_speed(drv.mspd),
        .out_valid(out_valid), .out_stall(out_stall),
        .reference_position(got.rpos), .reference_speed(got.rspd),
        .stream_running(got.active), .armed(got.armed),
        .accepted_pulses(got.acc), .ignored_pulses(got.ign),
        .peak_position_error(got.pk_pos), .peak_speed_error(got.pk_spd),
        .tracking_started(got.started), .first_error_position(got.first),
        .last_step_error(got.last), .motion_samples(got.motion)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // configuration copy
    logic [9:0]  cfg_cpp;
    logic        cfg_inv;
    logic [15:0] cfg_tpm;
    logic [19:0] cfg_thr;
    logic [31:0] cfg_num;

    // servo reference state
    logic signed [31:0] s_ref;
    logic [31:0]        s_pending;
    logic [31:0]        s_last_t;
    logic [31:0]        s_ival;
    logic               s_neg;
    logic               s_ival_ok;
    logic               s_armed;
    logic               s_active;
    logic signed [31:0] s_spd;
    logic [31:0]        s_acc;
    logic [31:0]        s_ign;
    logic [30:0]        s_pk_pos;
    logic [30:0]        s_pk_spd;
    logic               s_started;
    logic signed [31:0] s_first;
    logic signed [31:0] s_last;
    logic [31:0]        s_motion;

    status_t expected_status[$];
    int errors = 0;
    int results_seen = 0;
    int sender_idle_pct = 0;
    int stall_pct = 0;
    int hold_cycles = 0;
    longint cycles = 0;

    function automatic logic signed [31:0] sat32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [30:0] mag31(input logic signed [31:0] v);
        logic [31:0] n;
        n = -v;
        if (v == 32'sh8000_0000)
            return 31'h7FFF_FFFF;
        return v[31] ? n[30:0] : v[30:0];
    endfunction

    task automatic servo_clear();
        s_ref = 0; s_pending = 0; s_last_t = 0; s_ival = 0; s_neg = 0;
        s_ival_ok = 0; s_armed = 0; s_active = 0; s_spd = 0; s_acc = 0;
        s_ign = 0; s_pk_pos = 0; s_pk_spd = 0; s_started = 0; s_first = 0;
        s_last = 0; s_motion = 0;
    endtask

    task automatic predict_status(input event_t e);
        logic               up;
        logic [31:0]        elapsed;
        logic [47:0]        lhs;
        logic [47:0]        rhs;
        logic [31:0]        delta;
        longint             spd;
        logic signed [31:0] perr;
        logic signed [31:0] serr;
        logic [30:0]        ap;
        logic [30:0]        as;
        status_t            r;
        case (e.op)
            sdp_pkg::OP_ARM:
            begin
                servo_clear();
                s_ref = e.mpos;
                s_last_t = e.ts;
                s_armed = 1;
            end
            sdp_pkg::OP_DISARM:
            begin
                s_armed = 0;
                s_spd = 0;
            end
            sdp_pkg::OP_STEP:
            begin
                if (!s_armed || !e.en)
                    s_ign++;
                else
                begin
                    up = e.dir ^ cfg_inv;
                    s_ref = sat32(longint'(s_ref) + (up ? longint'(cfg_cpp)
                                                         : -longint'(cfg_cpp)));
                    if (s_ival_ok)
                        s_ival = e.ts - s_last_t;
                    s_last_t = e.ts;
                    s_neg = !up;
                    s_ival_ok = 1;
                    s_pending += up ? 32'd1 : 32'hFFFF_FFFF;
                    s_acc++;
                end
            end
            sdp_pkg::OP_FAST:
            begin
                if (s_armed)
                begin
                    s_active = 0;
                    if (e.en && s_ival_ok && s_ival != 0)
                    begin
                        elapsed = e.ts - s_last_t;
                        lhs = 48'(elapsed) * 48'd1000;
                        rhs = 48'(s_ival) * 48'(cfg_tpm);
                        s_active = lhs <= rhs;
                    end
                end
            end
            sdp_pkg::OP_SLOW:
            begin
                if (s_armed)
                begin
                    delta = e.en ? s_pending : 32'd0;
                    s_pending = 0;
                    spd = 0;
                    if (s_ival_ok && s_ival != 0 && s_active)
                    begin
                        spd = longint'(cfg_num / s_ival);
                        if (s_neg)
                            spd = -spd;
                    end
                    s_spd = sat32(spd);
                    if (delta != 0 || s_spd != 0)
                    begin
                        perr = sat32(longint'(s_ref) - longint'(e.mpos));
                        serr = sat32(longint'(s_spd) - longint'(e.mspd));
                        ap = mag31(perr);
                        as = mag31(serr);
                        if (ap > s_pk_pos)
                            s_pk_pos = ap;
                        if (!s_started && {1'b0, ap} >= 32'(cfg_thr))
                        begin
                            s_started = 1;
                            s_first = perr;
                        end
                        if (as > s_pk_spd)
                            s_pk_spd = as;
                        s_motion++;
                    end
                    if (delta != 0)
                        s_last = sat32(longint'(s_ref) - longint'(e.mpos));
                end
            end
            default:
            begin
            end
        endcase
        r.rpos = s_ref; r.rspd = s_spd; r.active = s_active; r.armed = s_armed;
        r.acc = s_acc; r.ign = s_ign; r.pk_pos = s_pk_pos; r.pk_spd = s_pk_spd;
        r.started = s_started; r.first = s_first; r.last = s_last;
        r.motion = s_motion;
        expected_status.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input longint g, input longint x);
        errors++;
        $display("MISMATCH %s: got %0h expected %0h (result %0d)", what, g, x,
                 results_seen);
    endtask

    // compare results
    always @(posedge clk)
    begin
        status_t x;
        cycles++;
        if (cycles > 64'd2000000)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_status.size() == 0)
                report_mismatch("unexpected result", got.rpos, 0);
            else
            begin
                x = expected_status.pop_front();
                if (got.rpos !== x.rpos) report_mismatch("reference_position", got.rpos, x.rpos);
                if (got.rspd !== x.rspd) report_mismatch("reference_speed", got.rspd, x.rspd);
                if (got.active !== x.active)
                    report_mismatch("stream_running", got.active, x.active);
                if (got.armed !== x.armed) report_mismatch("armed", got.armed, x.armed);
                if (got.acc !== x.acc) report_mismatch("accepted_pulses", got.acc, x.acc);
                if (got.ign !== x.ign) report_mismatch("ignored_pulses", got.ign, x.ign);
                if (got.pk_pos !== x.pk_pos)
                    report_mismatch("peak_position_error", got.pk_pos, x.pk_pos);
                if (got.pk_spd !== x.pk_spd)
                    report_mismatch("peak_speed_error", got.pk_spd, x.pk_spd);
                if (got.started !== x.started)
                    report_mismatch("tracking_started", got.started, x.started);
                if (got.first !== x.first)
                    report_mismatch("first_error_position", got.first, x.first);
                if (got.last !== x.last) report_mismatch("last_step_error", got.last, x.last);
                if (got.motion !== x.motion)
                    report_mismatch("motion_samples", got.motion, x.motion);
            end
            results_seen++;
        end
    end

    // receiver stall, with an optional long hold-off
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge clk);
        penable <= 1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            sdp_pkg::REG_CPP:  cfg_cpp = val[9:0];
            sdp_pkg::REG_DINV: cfg_inv = val[0];
            sdp_pkg::REG_TPM:  cfg_tpm = val[15:0];
            sdp_pkg::REG_THR:  cfg_thr = val[19:0];
            sdp_pkg::REG_SNUM: cfg_num = val;
            default: ;
        endcase
    endtask

    // valid stays high across back-to-back items; drop it only while idling
    task automatic send_event(input event_t e);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        drv <= e;
        in_valid <= 1'b1;
        predict_status(e);
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_status.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    function automatic event_t mk(input logic [2:0] o, input logic [31:0] t,
                                  input logic d, input logic en,
                                  input logic [31:0] p, input logic [31:0] s);
        event_t e;
        e.op = o; e.ts = t; e.dir = d; e.en = en; e.mpos = p; e.mspd = s;
        return e;
    endfunction

    function automatic event_t rand_noise();
        return mk($urandom_range(7), $urandom, $urandom, $urandom, $urandom, $urandom);
    endfunction

    task automatic test_directed();
        send_event(mk(sdp_pkg::OP_STEP, 0, 1, 1, 0, 0));
        send_event(mk(sdp_pkg::OP_FAST, 10, 1, 1, 0, 0));
        send_event(mk(sdp_pkg::OP_SLOW, 10, 1, 1, 0, 0));
        send_event(mk(sdp_pkg::OP_ARM, 32'hFFFF_FFF0, 0, 0, 32'h7FFF_FFFE, 0));
        send_event(mk(sdp_pkg::OP_STEP, 32'hFFFF_FFF8, 1, 1, 0, 0));
        send_event(mk(sdp_pkg::OP_STEP, 32'h0000_0010, 1, 1, 0, 0));
        send_event(mk(sdp_pkg::OP_STEP, 32'h0000_0020, 1, 0, 0, 0));
        send_event(mk(sdp_pkg::OP_FAST, 32'h0000_0040, 1, 1, 0, 0));
        send_event(mk(sdp_pkg::OP_SLOW, 32'h0000_0040, 1, 1, 32'h8000_0000, 32'h7FFF_FFFF));
        send_event(mk(sdp_pkg::OP_FAST, 32'h0000_0030, 1, 0, 0, 0));
        send_event(mk(sdp_pkg::OP_SLOW, 32'h0000_0040, 1, 0, 0, 0));
        send_event(mk(sdp_pkg::OP_ARM, 100, 0, 1, 32'h8000_0001, 0));
        send_event(mk(sdp_pkg::OP_STEP, 110, 0, 1, 0, 0));
        send_event(mk(sdp_pkg::OP_STEP, 111, 0, 1, 0, 0));
        send_event(mk(sdp_pkg::OP_FAST, 111, 0, 1, 0, 0));
        send_event(mk(sdp_pkg::OP_SLOW, 111, 0, 1, 32'h7FFF_FFFF, 32'h8000_0000));
        send_event(mk(3'd5, 0, 1, 1, 0, 0));
        send_event(mk(3'd7, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_event(mk(sdp_pkg::OP_DISARM, 0, 0, 0, 0, 0));
        send_event(mk(sdp_pkg::OP_STEP, 200, 1, 1, 0, 0));
        send_event(mk(sdp_pkg::OP_SLOW, 200, 1, 1, 0, 0));
        drain();
    endtask

    // armed motion profile: steps at a random pitch with ticks, re-arms, noise items and disarms mixed in
    task automatic test_motion(input int n);
        logic [31:0] t;
        logic [31:0] pitch;
        logic [31:0] pos;
        logic        d;
        int          k;
        t = $urandom;
        pos = $urandom;
        d = $urandom;
        pitch = 1;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            if (k < 3)
            begin
                send_event(mk(sdp_pkg::OP_ARM, t, d, 1, pos, $urandom));
                pitch = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 2000);
            end
            else if (k < 5)
                send_event(rand_noise());
            else if (k < 50)
            begin
                t += pitch + $urandom_range(pitch / 4);
                if ($urandom_range(9) == 0)
                    d = ~d;
                send_event(mk(sdp_pkg::OP_STEP, t, d, $urandom_range(19) != 0,
                              $urandom, $urandom));
            end
            else if (k < 75)
                send_event(mk(sdp_pkg::OP_FAST, t + $urandom_range(2 * pitch), d,
                              $urandom_range(9) != 0, $urandom, $urandom));
            else if (k < 97)
                send_event(mk(sdp_pkg::OP_SLOW, t, d, $urandom_range(9) != 0,
                              s_ref + $signed($urandom_range(40)) - 20,
                              ($urandom_range(1) ? $urandom : s_spd + $urandom_range(99))));
            else
                send_event(mk(sdp_pkg::OP_DISARM, t, d, 1, 0, 0));
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        test_motion(20);
        drain();
        sender_idle_pct = 0;
        test_motion(10);
        drain();
    endtask

    task automatic test_config(input logic [9:0] cpp, input logic inv, input logic [15:0] tpm,
                               input logic [19:0] thr, input logic [31:0] num, input int n);
        write_reg(sdp_pkg::REG_CPP, cpp);
        write_reg(sdp_pkg::REG_DINV, inv);
        write_reg(sdp_pkg::REG_TPM, tpm);
        write_reg(sdp_pkg::REG_THR, thr);
        write_reg(sdp_pkg::REG_SNUM, num);
        test_motion(n);
        drain();
    endtask

    initial
    begin
        cfg_cpp = sdp_pkg::CPP_RST; cfg_inv = 0; cfg_tpm = sdp_pkg::TPM_RST;
        cfg_thr = sdp_pkg::THR_RST; cfg_num = sdp_pkg::SNUM_RST;
        servo_clear();
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_config(sdp_pkg::CPP_RST, 0, sdp_pkg::TPM_RST, sdp_pkg::THR_RST,
                    sdp_pkg::SNUM_RST, 300);
        sender_idle_pct = 81;
        test_config(10'd1, 1, 16'd1000, 20'd0, 32'd1, 250);
        sender_idle_pct = 0; stall_pct = 81;
        test_config(10'd1000, 0, 16'hFFFF, 20'd1000000, 32'hFFFF_FFFF, 250);
        sender_idle_pct = 28; stall_pct = 28;
        test_config(10'h3FF, 1, 16'd2000, 20'hFFFFF, 32'd123456789, 250);
        sender_idle_pct = 0; stall_pct = 0;
        test_config(10'd0, 0, 16'd1300, 20'd50, $urandom, 250);
        test_backpressure();
        $display("covered %0d results across five register settings, idle mixes and hold-off",
                 results_seen);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

>>> step_dir_pulse_reference.f
design/sdp_pkg.sv
design/sdp_front.sv
design/sdp_div.sv
design/sdp_back.sv
design/step_dir_pulse_reference.sv
sim/step_dir_pulse_reference_test.sv
